@@ rtl/core/ssn_pkg.sv @@
// Shared types, codes and defaults of the shape surface normal unit.
package ssn_pkg;

	localparam int SHAPE_COUNT_DEF   = 256;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int MATRIX_ENTRIES    = 12;
	localparam int CFG_W             = 18;
	localparam int CFG_IDX_W         = 2;
	localparam int NORMAL_W          = 18;

	localparam logic [1:0] CMD_QUERY = 2'd0;
	localparam logic [1:0] CMD_MAT   = 2'd1;
	localparam logic [1:0] CMD_KIND  = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam logic [1:0] KIND_SPHERE   = 2'd0;
	localparam logic [1:0] KIND_PLANE    = 2'd1;
	localparam logic [1:0] KIND_CUBE     = 2'd2;
	localparam logic [1:0] KIND_TRIANGLE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TRI_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRI_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRI_Z = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic               id_ok;
		logic               idx_ok;
		logic [7:0]         shape_id;
		logic [3:0]         entry_index;
		logic signed [31:0] write_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} ssn_item_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] x;
		logic signed [CFG_W-1:0] y;
		logic signed [CFG_W-1:0] z;
	} ssn_tri_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ssn_qstat_t;

endpackage

@@ rtl/core/ssn_channels.sv @@
// Request and response channel interfaces of the shape surface normal unit.
interface ssn_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [7:0]         shape_id;
	logic [3:0]         entry_index;
	logic signed [31:0] write_value;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source (output valid, cmd, shape_id, entry_index, write_value,
		point_x, point_y, point_z, input ready);
	modport sink (input valid, cmd, shape_id, entry_index, write_value,
		point_x, point_y, point_z, output ready);
endinterface

interface ssn_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] normal_x;
	logic signed [17:0] normal_y;
	logic signed [17:0] normal_z;
	logic               degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate,
		input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
		output ready);
endinterface

@@ rtl/core/shape_surface_normal_unit.sv @@
// Top level of the shape surface normal unit: config registers, front, queue, back.
//
// The unit keeps a table of SHAPE_COUNT shapes, each a 3x4 affine inverse
// transform and a kind, loaded by write items on the request channel, and
// answers a query item with one unit world-space normal. Items enter a two-
// entry queue so the request side keeps moving while the back end works; the
// back end handles one item at a time in order. A matrix or kind write is
// done as the back end takes the item; unused command codes are dropped at
// the front and give no result. A query on a shape beyond the table goes
// straight to the final state and gives a degenerate result. A regular
// query reads its twelve matrix words from the table RAM, forms the
// object-space point and then the world vector on one shared 32x32
// multiplier, applies one-bit normalizing shifts, sums the squares, takes
// the bit-serial square root and ends with the three restoring divisions.
// A finished result waits in the output register while the next item is
// already being taken. The tables are not cleared: query only shapes whose
// matrix entries and kind have been written.
// Write the triangle normal registers only while the unit is idle.
module shape_surface_normal_unit #(
	parameter int SHAPE_COUNT   = ssn_pkg::SHAPE_COUNT_DEF,
	parameter int FRACTION_BITS = ssn_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ssn_req_if.sink                       req,
	ssn_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [ssn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssn_pkg::CFG_W-1:0]     cfg_data
);
	import ssn_pkg::*;

	ssn_tri_t   tri_q;
	ssn_item_t  push_item;
	ssn_item_t  head;
	ssn_qstat_t qstat;
	logic       push;
	logic       pop;

	// triangle normal registers; an index past the last register is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_q.x <= '0;
			tri_q.y <= '0;
			tri_q.z <= 18'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRI_X: tri_q.x <= cfg_data;
				REG_TRI_Y: tri_q.y <= cfg_data;
				REG_TRI_Z: tri_q.z <= cfg_data;
				default:   ;
			endcase
		end
	end

	// accept and classify items
	ssn_front #(.SHAPE_COUNT(SHAPE_COUNT)) u_front (
		.req(req), .qstat(qstat), .push(push), .item(push_item)
	);

	// hold items until the back end is free
	ssn_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .head(head), .qstat(qstat)
	);

	// carry out writes and queries in order
	ssn_back #(.SHAPE_COUNT(SHAPE_COUNT), .FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .qstat(qstat), .pop(pop),
		.tri_n(tri_q), .rsp(rsp)
	);
endmodule

@@ rtl/core/ssn_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ssn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/ssn_front.sv @@
// Front end: accepts request items, drops unused commands, tags range checks.
module ssn_front #(
	parameter int SHAPE_COUNT = ssn_pkg::SHAPE_COUNT_DEF
) (
	ssn_req_if.sink             req,
	input  ssn_pkg::ssn_qstat_t qstat,
	output logic                push,
	output ssn_pkg::ssn_item_t  item
);
	import ssn_pkg::*;

	assign req.ready = !qstat.full;

	always_comb begin
		item.cmd         = req.cmd;
		item.id_ok       = 32'(req.shape_id) < SHAPE_COUNT;
		item.idx_ok      = 32'(req.entry_index) < MATRIX_ENTRIES;
		item.shape_id    = req.shape_id;
		item.entry_index = req.entry_index;
		item.write_value = req.write_value;
		item.point_x     = req.point_x;
		item.point_y     = req.point_y;
		item.point_z     = req.point_z;
		// drop the unused command code here, it never reaches the back end
		case (req.cmd)
			CMD_QUERY, CMD_MAT, CMD_KIND: push = req.valid && !qstat.full;
			default:                      push = 1'b0;
		endcase
	end
endmodule

@@ rtl/core/ssn_queue.sv @@
// Two-entry item queue between front and back end.
module ssn_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ssn_pkg::ssn_item_t  push_item,
	input  logic                pop,
	output ssn_pkg::ssn_item_t  head,
	output ssn_pkg::ssn_qstat_t qstat
);
	import ssn_pkg::*;

	ssn_item_t  slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign head        = slot_q[rptr_q];
	assign qstat.full  = count_q == 2'd2;
	assign qstat.empty = count_q == 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end
endmodule

@@ rtl/core/ssn_back.sv @@
// Back end: table writes and the sequenced normal computation per query.
module ssn_back #(
	parameter int SHAPE_COUNT   = ssn_pkg::SHAPE_COUNT_DEF,
	parameter int FRACTION_BITS = ssn_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ssn_pkg::ssn_item_t  head,
	input  ssn_pkg::ssn_qstat_t qstat,
	output logic                pop,
	input  ssn_pkg::ssn_tri_t   tri_n,
	ssn_rsp_if.source           rsp
);
	import ssn_pkg::*;

	localparam int MDEPTH = SHAPE_COUNT * MATRIX_ENTRIES;
	localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int KAW    = (SHAPE_COUNT > 1) ? $clog2(SHAPE_COUNT) : 1;
	localparam int QB     = FRACTION_BITS + 3;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_LOAD    = 5'd1;
	localparam logic [4:0] S_OMUL    = 5'd2;
	localparam logic [4:0] S_OACC    = 5'd3;
	localparam logic [4:0] S_NSEL    = 5'd4;
	localparam logic [4:0] S_WMUL    = 5'd5;
	localparam logic [4:0] S_WACC    = 5'd6;
	localparam logic [4:0] S_MAX     = 5'd7;
	localparam logic [4:0] S_SHIFT   = 5'd8;
	localparam logic [4:0] S_SQMUL   = 5'd9;
	localparam logic [4:0] S_SQACC   = 5'd10;
	localparam logic [4:0] S_SQRT    = 5'd11;
	localparam logic [4:0] S_DIVINIT = 5'd12;
	localparam logic [4:0] S_DIV     = 5'd13;
	localparam logic [4:0] S_FIN     = 5'd14;

	logic [4:0] state_q;
	logic [5:0] cnt_q;
	logic [1:0] r_q;
	logic [1:0] c_q;
	logic       out_valid_q;

	logic signed [31:0] mat_q [MATRIX_ENTRIES];
	logic signed [31:0] pnt_q [3];
	logic signed [31:0] o_q [3];
	logic signed [31:0] nrm_q [3];
	logic signed [63:0] v_q [3];
	logic signed [17:0] res_q [3];
	logic [7:0]         id_q;
	logic [MAW-1:0]     base_q;
	logic [1:0]         kind_q;
	logic               deg_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod_q;
	logic [62:0]        m_q;
	logic [63:0]        sq_x_q;
	logic [63:0]        sq_r_q;
	logic [63:0]        sq_b_q;
	logic [31:0]        len_q;
	logic [63:0]        num_q;
	logic [31:0]        rem_q;
	logic [QB-1:0]      quo_q;
	logic signed [17:0] out_x_q;
	logic signed [17:0] out_y_q;
	logic signed [17:0] out_z_q;
	logic               out_deg_q;

	logic               m_we;
	logic [MAW-1:0]     m_waddr;
	logic [MAW-1:0]     m_raddr;
	logic [31:0]        m_rdata;
	logic               k_we;
	logic [1:0]         k_rdata;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod_d;
	logic signed [63:0] acc_o;
	logic signed [63:0] acc_w;
	logic signed [31:0] o_sat;
	logic [62:0]        vmag [3];
	logic [62:0]        vmax;
	logic signed [31:0] u_sel;
	logic [31:0]        a_abs;
	logic [63:0]        sq_t;
	logic               sq_ge;
	logic [63:0]        sq_x_n;
	logic [63:0]        sq_r_n;
	logic [63:0]        num_d;
	logic [32:0]        rem2;
	logic               div_ge;
	logic [QB-1:0]      quo_n;
	logic signed [17:0] q_fin;
	logic [32:0]        ax;
	logic [32:0]        ay;
	logic [32:0]        az;
	logic               fin_load;

	assign pop = (state_q == S_IDLE) && !qstat.empty;

	assign m_we    = pop && (head.cmd == CMD_MAT) && head.id_ok && head.idx_ok;
	assign k_we    = pop && (head.cmd == CMD_KIND) && head.id_ok;
	assign m_waddr = MAW'(12'(head.shape_id) * 12'(MATRIX_ENTRIES) + 12'(head.entry_index));
	assign m_raddr = base_q + MAW'(cnt_q[3:0]);

	ssn_ram #(.WIDTH(32), .DEPTH(MDEPTH)) u_mat_ram (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(head.write_value),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	ssn_ram #(.WIDTH(2), .DEPTH(SHAPE_COUNT)) u_kind_ram (
		.clk(clk), .we(k_we), .waddr(KAW'(head.shape_id)),
		.wdata(head.write_value[1:0]), .raddr(KAW'(id_q)), .rdata(k_rdata)
	);

	// shared multiplier operand selection
	always_comb begin
		mul_a = mat_q[{r_q, c_q}];
		mul_b = nrm_q[r_q];
		u_sel = v_q[c_q][31:0];
		case (state_q)
			S_OMUL: begin
				case (c_q)
					2'd0:    mul_b = pnt_q[0];
					2'd1:    mul_b = pnt_q[1];
					2'd2:    mul_b = pnt_q[2];
					default: mul_b = 32'sd1 <<< FRACTION_BITS;
				endcase
			end
			S_SQMUL: begin
				mul_a = u_sel;
				mul_b = u_sel;
			end
			default: ;
		endcase
	end

	assign prod_d = mul_a * mul_b;
	assign acc_o  = acc_q + (prod_q >>> FRACTION_BITS);
	assign acc_w  = acc_q + (prod_q >>> 2);

	always_comb begin
		if (acc_o > 64'sd2147483647) begin
			o_sat = 32'sh7FFFFFFF;
		end else if (acc_o < -64'sd2147483648) begin
			o_sat = 32'sh80000000;
		end else begin
			o_sat = acc_o[31:0];
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vmag[k] = v_q[k][63] ? 63'(-v_q[k]) : v_q[k][62:0];
		end
		vmax = vmag[0];
		if (vmag[1] > vmax) vmax = vmag[1];
		if (vmag[2] > vmax) vmax = vmag[2];
	end

	always_comb begin
		ax = o_q[0][31] ? 33'(-{o_q[0][31], o_q[0]}) : {1'b0, o_q[0]};
		ay = o_q[1][31] ? 33'(-{o_q[1][31], o_q[1]}) : {1'b0, o_q[1]};
		az = o_q[2][31] ? 33'(-{o_q[2][31], o_q[2]}) : {1'b0, o_q[2]};
	end

	// one restoring square-root step
	always_comb begin
		sq_t   = sq_r_q + sq_b_q;
		sq_ge  = sq_x_q >= sq_t;
		sq_x_n = sq_ge ? sq_x_q - sq_t : sq_x_q;
		sq_r_n = sq_ge ? (sq_r_q >> 1) + sq_b_q : sq_r_q >> 1;
	end

	// one restoring division step and the final round, sign and clamp
	always_comb begin
		a_abs  = u_sel[31] ? 32'(-u_sel) : u_sel;
		num_d  = ({32'd0, a_abs} << FRACTION_BITS) + {33'd0, len_q[31:1]};
		rem2   = {rem_q, num_q[cnt_q]};
		div_ge = rem2 >= {1'b0, len_q};
		quo_n  = {quo_q[QB-2:0], div_ge};
		if (u_sel[31]) begin
			q_fin = (34'(quo_n) > 34'd131072) ? -18'sd131072 : 18'(-quo_n);
		end else begin
			q_fin = (34'(quo_n) > 34'd131071) ? 18'sd131071 : 18'(quo_n);
		end
	end

	assign fin_load = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 6'd0;
			r_q         <= 2'd0;
			c_q         <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop && head.cmd == CMD_QUERY) begin
						cnt_q   <= 6'd0;
						state_q <= head.id_ok ? S_LOAD : S_FIN;
					end
				end
				S_LOAD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(MATRIX_ENTRIES)) begin
						r_q     <= 2'd0;
						c_q     <= 2'd0;
						state_q <= S_OMUL;
					end
				end
				S_OMUL: state_q <= S_OACC;
				S_OACC: begin
					state_q <= S_OMUL;
					if (c_q == 2'd3) begin
						c_q <= 2'd0;
						if (r_q == 2'd2) begin
							state_q <= S_NSEL;
						end else begin
							r_q <= r_q + 2'd1;
						end
					end else begin
						c_q <= c_q + 2'd1;
					end
				end
				S_NSEL: begin
					r_q     <= 2'd0;
					c_q     <= 2'd0;
					state_q <= S_WMUL;
				end
				S_WMUL: state_q <= S_WACC;
				S_WACC: begin
					state_q <= S_WMUL;
					if (r_q == 2'd2) begin
						r_q <= 2'd0;
						if (c_q == 2'd2) begin
							state_q <= S_MAX;
						end else begin
							c_q <= c_q + 2'd1;
						end
					end else begin
						r_q <= r_q + 2'd1;
					end
				end
				S_MAX: state_q <= S_SHIFT;
				S_SHIFT: begin
					if (m_q == 63'd0) begin
						state_q <= S_FIN;
					end else if (m_q < (63'd1 << 30) && m_q >= (63'd1 << 29)) begin
						c_q     <= 2'd0;
						state_q <= S_SQMUL;
					end
				end
				S_SQMUL: state_q <= S_SQACC;
				S_SQACC: begin
					if (c_q == 2'd2) begin
						cnt_q   <= 6'd0;
						state_q <= S_SQRT;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_SQMUL;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						c_q     <= 2'd0;
						state_q <= S_DIVINIT;
					end
				end
				S_DIVINIT: begin
					cnt_q   <= 6'(QB - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 6'd0) begin
						if (c_q == 2'd2) begin
							state_q <= S_FIN;
						end else begin
							c_q     <= c_q + 2'd1;
							state_q <= S_DIVINIT;
						end
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop) begin
					pnt_q[0] <= head.point_x;
					pnt_q[1] <= head.point_y;
					pnt_q[2] <= head.point_z;
					id_q     <= head.shape_id;
					base_q   <= MAW'(12'(head.shape_id) * 12'(MATRIX_ENTRIES));
					deg_q    <= !head.id_ok;
					for (int k = 0; k < 3; k++) begin
						res_q[k] <= '0;
					end
				end
			end
			S_LOAD: begin
				if (cnt_q != 6'd0) begin
					mat_q[cnt_q[3:0] - 4'd1] <= m_rdata;
				end
				if (cnt_q == 6'd1) begin
					kind_q <= k_rdata;
				end
				acc_q <= '0;
			end
			S_OMUL, S_WMUL, S_SQMUL: prod_q <= prod_d;
			S_OACC: begin
				if (c_q == 2'd3) begin
					o_q[r_q] <= o_sat;
					acc_q    <= '0;
				end else begin
					acc_q <= acc_o;
				end
			end
			S_NSEL: begin
				acc_q <= '0;
				case (kind_q)
					KIND_SPHERE: begin
						nrm_q[0] <= o_q[0];
						nrm_q[1] <= o_q[1];
						nrm_q[2] <= o_q[2];
					end
					KIND_PLANE: begin
						nrm_q[0] <= '0;
						nrm_q[1] <= 32'sd1 <<< FRACTION_BITS;
						nrm_q[2] <= '0;
					end
					KIND_CUBE: begin
						// keep the largest magnitude, ties favor x then y
						nrm_q[0] <= '0;
						nrm_q[1] <= '0;
						nrm_q[2] <= '0;
						if (ax >= ay && ax >= az) begin
							nrm_q[0] <= o_q[0];
						end else if (ay >= az) begin
							nrm_q[1] <= o_q[1];
						end else begin
							nrm_q[2] <= o_q[2];
						end
					end
					default: begin
						nrm_q[0] <= 32'(tri_n.x);
						nrm_q[1] <= 32'(tri_n.y);
						nrm_q[2] <= 32'(tri_n.z);
					end
				endcase
			end
			S_WACC: begin
				if (r_q == 2'd2) begin
					v_q[c_q] <= acc_w;
					acc_q    <= '0;
				end else begin
					acc_q <= acc_w;
				end
			end
			S_MAX: begin
				m_q    <= vmax;
				sq_x_q <= '0;
			end
			S_SHIFT: begin
				if (m_q == 63'd0) begin
					deg_q <= 1'b1;
				end else if (m_q >= (63'd1 << 30)) begin
					m_q <= m_q >> 1;
					for (int k = 0; k < 3; k++) begin
						v_q[k] <= v_q[k] >>> 1;
					end
				end else if (m_q < (63'd1 << 29)) begin
					m_q <= m_q << 1;
					for (int k = 0; k < 3; k++) begin
						v_q[k] <= v_q[k] <<< 1;
					end
				end
			end
			S_SQACC: begin
				sq_x_q <= sq_x_q + 64'(prod_q);
				sq_r_q <= '0;
				sq_b_q <= 64'd1 << 62;
			end
			S_SQRT: begin
				sq_x_q <= sq_x_n;
				sq_r_q <= sq_r_n;
				sq_b_q <= sq_b_q >> 2;
				if (cnt_q == 6'd31) begin
					len_q <= sq_r_n[31:0];
				end
			end
			S_DIVINIT: begin
				num_q <= num_d;
				rem_q <= 32'(num_d >> QB);
				quo_q <= '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? 32'(rem2 - {1'b0, len_q}) : rem2[31:0];
				quo_q <= quo_n;
				if (cnt_q == 6'd0) begin
					res_q[c_q] <= q_fin;
				end
			end
			S_FIN: begin
				if (fin_load) begin
					out_x_q   <= res_q[0];
					out_y_q   <= res_q[1];
					out_z_q   <= res_q[2];
					out_deg_q <= deg_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.normal_x   = out_x_q;
	assign rsp.normal_y   = out_y_q;
	assign rsp.normal_z   = out_z_q;
	assign rsp.degenerate = out_deg_q;
endmodule

@@ rtl/core/ssn_checker.sv @@
// Port-level checks on the response channel of the shape surface normal unit.
module ssn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [17:0] normal_x,
	input logic [17:0] normal_y,
	input logic [17:0] normal_z,
	input logic        degenerate
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("response item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable({normal_x, normal_y, normal_z, degenerate}))
		else $error("response item changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && degenerate |-> normal_x == 18'd0 && normal_y == 18'd0
			&& normal_z == 18'd0)
		else $error("degenerate item with nonzero normal");

	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !degenerate |-> normal_x != 18'd0 || normal_y != 18'd0
			|| normal_z != 18'd0)
		else $error("normalized item is all zero");
endmodule

bind shape_surface_normal_unit ssn_checker u_ssn_checker (
	.clk(clk), .arst_n(arst_n), .valid(rsp.valid), .ready(rsp.ready),
	.normal_x(rsp.normal_x), .normal_y(rsp.normal_y), .normal_z(rsp.normal_z),
	.degenerate(rsp.degenerate)
);
